// File: rtl/local_map_window_shift_defines.svh
// Assertion macros shared by the local map window RTL.
`ifndef LOCAL_MAP_WINDOW_SHIFT_DEFINES_SVH
`define LOCAL_MAP_WINDOW_SHIFT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define LMWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define LMWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lmws_pkg.sv
// Types and constants shared by the local map window modules.
`default_nettype none

package lmws_pkg;

  // Coordinates: signed metres with 10 fraction bits.
  localparam int NUM_AXES = 3;
  localparam int COORD_W  = 32;
  localparam int WIDE_W   = COORD_W + 4;

  // Configuration register widths.
  localparam int SIDE_W     = 24;
  localparam int RANGE_W    = 24;
  localparam int THR_W      = 11;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Margin factor is in units of 1/256.
  localparam int THR_SHIFT = 8;
  localparam logic [THR_W:0] THR_ONE = (THR_W + 1)'(256);

  // Derived length widths.
  localparam int MARGIN_W = THR_W + RANGE_W - THR_SHIFT;
  localparam int MOV_W    = 30;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CUBE_SIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_RANGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR     = 2'd2;

  // Register reset values.
  localparam logic [SIDE_W-1:0]  CUBE_SIDE_RST    = 24'd122880;
  localparam logic [RANGE_W-1:0] DETECT_RANGE_RST = 24'd460800;
  localparam logic [THR_W-1:0]   MOVE_THR_RST     = 11'd384;

  // Cycles the derived lengths take to follow a register write.
  localparam int SETTLE_W = 3;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd4;

  // Stream payload widths.
  localparam int IN_W  = NUM_AXES * COORD_W;
  localparam int OUT_W = 2 * NUM_AXES * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Lengths derived from the registers, stable while items flow.
  typedef struct packed {
    logic [MARGIN_W-1:0]     margin;
    logic signed [MOV_W-1:0] mov;
    logic [SIDE_W-1:0]       side;
  } geom_t;

  // Everything one position yields: old cube, moved axes and slab cuts.
  typedef struct packed {
    logic                                 has_box;
    logic [NUM_AXES-1:0]                  hit;
    logic [NUM_AXES-1:0]                  at_min;
    logic [NUM_AXES-1:0][COORD_W-1:0]     lo;
    logic [NUM_AXES-1:0][COORD_W-1:0]     hi;
    logic [NUM_AXES-1:0][COORD_W-1:0]     cut;
  } batch_t;

endpackage

`default_nettype wire

// File: rtl/lmws_cfg.sv
// Configuration registers and the pipeline that derives margin and move distance.
`default_nettype none

`include "local_map_window_shift_defines.svh"

module lmws_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [lmws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lmws_pkg::CFG_DATA_W-1:0] cfg_data,
  output      logic                            settled,
  output      lmws_pkg::geom_t                 geom
);

  localparam int T2P_W   = lmws_pkg::RANGE_W + lmws_pkg::THR_W + 2;
  localparam int T2_W    = T2P_W - lmws_pkg::THR_SHIFT;
  localparam int D_W     = 30;
  localparam int P_W     = D_W + 4;
  localparam int Q_W     = P_W - 2;
  localparam int QUO_W   = 30;
  localparam int R5_SH   = 34;
  localparam logic [Q_W-1:0] RECIP5 = 32'hCCCC_CCCD;

  logic [lmws_pkg::SIDE_W-1:0]   side_r;
  logic [lmws_pkg::RANGE_W-1:0]  range_r;
  logic [lmws_pkg::THR_W-1:0]    thr_r;
  logic [lmws_pkg::SETTLE_W-1:0] settle_r;
  logic                          cfg_fire;

  logic [lmws_pkg::THR_W+lmws_pkg::RANGE_W-1:0] margin_prod;
  logic signed [lmws_pkg::THR_W:0]              thr_m;
  logic signed [T2P_W-1:0]                      t2_prod;
  logic [lmws_pkg::MARGIN_W-1:0]                margin_r;
  logic signed [lmws_pkg::MOV_W-1:0]            t2_r;

  logic signed [D_W-1:0]   span;
  logic signed [P_W-1:0]   span_x;
  logic signed [P_W-1:0]   p_r;
  logic signed [Q_W-1:0]   q;
  logic [Q_W-1:0]          q_mag;
  logic [2*Q_W-1:0]        prod5;
  logic [QUO_W-1:0]        quo_r;
  logic                    neg_r;
  logic signed [lmws_pkg::MOV_W-1:0] t1;
  logic signed [lmws_pkg::MOV_W-1:0] mov_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign settled   = (settle_r == '0);

  // Hold the register file; a write to an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= lmws_pkg::CUBE_SIDE_RST;
      range_r  <= lmws_pkg::DETECT_RANGE_RST;
      thr_r    <= lmws_pkg::MOVE_THR_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        lmws_pkg::CFG_CUBE_SIDE:    side_r  <= cfg_data[lmws_pkg::SIDE_W-1:0];
        lmws_pkg::CFG_DETECT_RANGE: range_r <= cfg_data[lmws_pkg::RANGE_W-1:0];
        lmws_pkg::CFG_MOVE_THR:     thr_r   <= cfg_data[lmws_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Block input items until the derived lengths catch up with a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= lmws_pkg::SETTLE_CYCLES;
    end else if (cfg_fire) begin
      settle_r <= lmws_pkg::SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - lmws_pkg::SETTLE_W'(1);
    end
  end

  // Stage 1: margin = thr*range/256 and t2 = range*(thr-256)/256, floored.
  assign margin_prod = {{lmws_pkg::RANGE_W{1'b0}}, thr_r}
                     * {{lmws_pkg::THR_W{1'b0}}, range_r};
  assign thr_m   = $signed({1'b0, thr_r}) - $signed(lmws_pkg::THR_ONE);
  assign t2_prod = $signed({{(lmws_pkg::THR_W + 2){1'b0}}, range_r})
                 * $signed({{(lmws_pkg::RANGE_W + 1){thr_m[lmws_pkg::THR_W]}}, thr_m});

  always_ff @(posedge clk) begin
    margin_r <= margin_prod[lmws_pkg::THR_W+lmws_pkg::RANGE_W-1:lmws_pkg::THR_SHIFT];
    t2_r     <= {{(lmws_pkg::MOV_W - T2_W){t2_prod[T2P_W-1]}},
                 t2_prod[T2P_W-1:lmws_pkg::THR_SHIFT]};
  end

  // Stage 2: nine times the span left between the two margins.
  assign span   = $signed({{(D_W - lmws_pkg::SIDE_W){1'b0}}, side_r})
                - $signed({{(D_W - lmws_pkg::MARGIN_W - 1){1'b0}}, margin_r, 1'b0});
  assign span_x = {{(P_W - D_W){span[D_W-1]}}, span};

  always_ff @(posedge clk) begin
    p_r <= (span_x <<< 3) + span_x;
  end

  // Stage 3: floor by 4 as a shift, then magnitude times the reciprocal of 5.
  // A negative quotient is floored as -((|q| + 4) / 5).
  assign q     = p_r[P_W-1:2];
  assign q_mag = q[Q_W-1] ? (~q + Q_W'(5)) : q;
  assign prod5 = {{Q_W{1'b0}}, q_mag} * {{Q_W{1'b0}}, RECIP5};

  always_ff @(posedge clk) begin
    quo_r <= prod5[R5_SH+QUO_W-1:R5_SH];
    neg_r <= q[Q_W-1];
  end

  // Stage 4: restore the sign and take the larger of the two distances.
  assign t1 = neg_r ? $signed(~quo_r + QUO_W'(1)) : $signed(quo_r);

  always_ff @(posedge clk) begin
    mov_r <= (t1 > t2_r) ? t1 : t2_r;
  end

  assign geom.margin = margin_r;
  assign geom.mov    = mov_r;
  assign geom.side   = side_r;

  `LMWS_ASSERT_NXT(a_write_blocks_items, cfg_fire, !settled,
                   "input not held off after a register write")

endmodule

`default_nettype wire

// File: rtl/lmws_core.sv
// Input register, cube state and the single-pass face check per position.
`default_nettype none

`include "local_map_window_shift_defines.svh"

module lmws_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output      logic                       in_tready,
  input  wire logic [lmws_pkg::IN_W-1:0]  in_tdata,
  input  wire logic                       settled,
  input  wire lmws_pkg::geom_t            geom,
  input  wire logic                       obuf_free,
  output      logic                       load,
  output      lmws_pkg::batch_t           batch
);

  localparam int N  = lmws_pkg::NUM_AXES;
  localparam int CW = lmws_pkg::COORD_W;
  localparam int WW = lmws_pkg::WIDE_W;

  lmws_pkg::coord_t pos_r   [N];
  logic             pos_vld_r;
  lmws_pkg::coord_t lower_r [N];
  lmws_pkg::coord_t upper_r [N];
  logic             cube_ready_r;
  lmws_pkg::coord_t lower_nxt [N];
  lmws_pkg::coord_t upper_nxt [N];
  logic             proc_fire;
  logic             in_fire;

  logic signed [WW-1:0] wp [N];
  logic signed [WW-1:0] wl [N];
  logic signed [WW-1:0] wu [N];
  logic signed [WW-1:0] w_half;
  logic signed [WW-1:0] w_rest;
  logic signed [WW-1:0] w_mov;
  logic [WW-1:0]        w_margin;
  lmws_pkg::coord_t     place_lo [N];
  lmws_pkg::coord_t     place_hi [N];
  lmws_pkg::coord_t     dn_lo    [N];
  lmws_pkg::coord_t     dn_hi    [N];
  lmws_pkg::coord_t     up_lo    [N];
  lmws_pkg::coord_t     up_hi    [N];
  logic [N-1:0]         near_min;
  logic [N-1:0]         near_max;

  function automatic logic signed [WW-1:0] widen(input lmws_pkg::coord_t c);
    return {{(WW - CW){c[CW-1]}}, c};
  endfunction

  function automatic lmws_pkg::coord_t sat(input logic signed [WW-1:0] v);
    lmws_pkg::coord_t res;
    if ((&v[WW-1:CW-1]) || !(|v[WW-1:CW-1])) begin
      res = v[CW-1:0];
    end else if (v[WW-1]) begin
      res = {1'b1, {(CW - 1){1'b0}}};
    end else begin
      res = {1'b0, {(CW - 1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic [WW-1:0] mag(input logic signed [WW-1:0] v);
    return v[WW-1] ? (~v + WW'(1)) : v;
  endfunction

  assign proc_fire = pos_vld_r && obuf_free;
  assign in_tready = settled && (!pos_vld_r || proc_fire);
  assign in_fire   = in_tvalid && in_tready;

  // Capture the position; hold it while the result buffer is busy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= 1'b0;
    end else if (in_fire) begin
      pos_vld_r <= 1'b1;
    end else if (proc_fire) begin
      pos_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int a = 0; a < N; a++) begin
        pos_r[a] <= in_tdata[a*CW +: CW];
      end
    end
  end

  // Lengths widened once for all axes.
  assign w_half   = {{(WW - lmws_pkg::SIDE_W + 1){1'b0}}, geom.side[lmws_pkg::SIDE_W-1:1]};
  assign w_rest   = {{(WW - lmws_pkg::SIDE_W){1'b0}}, geom.side} - w_half;
  assign w_mov    = {{(WW - lmws_pkg::MOV_W){geom.mov[lmws_pkg::MOV_W-1]}}, geom.mov};
  assign w_margin = {{(WW - lmws_pkg::MARGIN_W){1'b0}}, geom.margin};

  // Check both faces and form placed, shifted-down and shifted-up corners per axis.
  always_comb begin
    for (int a = 0; a < N; a++) begin
      wp[a]       = widen(pos_r[a]);
      wl[a]       = widen(lower_r[a]);
      wu[a]       = widen(upper_r[a]);
      place_lo[a] = sat(wp[a] - w_half);
      place_hi[a] = sat(wp[a] + w_rest);
      near_min[a] = mag(wp[a] - wl[a]) <= w_margin;
      near_max[a] = mag(wp[a] - wu[a]) <= w_margin;
      dn_lo[a]    = sat(wl[a] - w_mov);
      dn_hi[a]    = sat(wu[a] - w_mov);
      up_lo[a]    = sat(wl[a] + w_mov);
      up_hi[a]    = sat(wu[a] + w_mov);
    end
  end

  // Next cube: place on the first position, else shift each touched axis.
  always_comb begin
    for (int a = 0; a < N; a++) begin
      if (!cube_ready_r) begin
        lower_nxt[a] = place_lo[a];
        upper_nxt[a] = place_hi[a];
      end else if (near_min[a]) begin
        lower_nxt[a] = dn_lo[a];
        upper_nxt[a] = dn_hi[a];
      end else if (near_max[a]) begin
        lower_nxt[a] = up_lo[a];
        upper_nxt[a] = up_hi[a];
      end else begin
        lower_nxt[a] = lower_r[a];
        upper_nxt[a] = upper_r[a];
      end
    end
  end

  // Advance the cube once per processed position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cube_ready_r <= 1'b0;
      for (int a = 0; a < N; a++) begin
        lower_r[a] <= '0;
        upper_r[a] <= '0;
      end
    end else if (proc_fire) begin
      cube_ready_r <= 1'b1;
      for (int a = 0; a < N; a++) begin
        lower_r[a] <= lower_nxt[a];
        upper_r[a] <= upper_nxt[a];
      end
    end
  end

  // Hand the old cube and the vacated slab bounds to the result buffer.
  always_comb begin
    batch.has_box = cube_ready_r && (|(near_min | near_max));
    batch.hit     = near_min | near_max;
    batch.at_min  = near_min;
    for (int a = 0; a < N; a++) begin
      batch.lo[a]  = lower_r[a];
      batch.hi[a]  = upper_r[a];
      batch.cut[a] = near_min[a] ? dn_hi[a] : up_lo[a];
    end
  end

  assign load = proc_fire;

  `LMWS_ASSERT_NXT(a_cube_placed, proc_fire, cube_ready_r,
                   "cube not marked placed after a position")
  `LMWS_ASSERT_IMP(a_no_item_unsettled, in_fire, settled,
                   "position taken while derived lengths are stale")

endmodule

`default_nettype wire

// File: rtl/lmws_obuf.sv
// Result buffer that plays out one empty result or up to three removal boxes.
`default_nettype none

`include "local_map_window_shift_defines.svh"

module lmws_obuf (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire lmws_pkg::batch_t            batch,
  output      logic                        free,
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [lmws_pkg::OUT_W-1:0]  out_tdata,  // rm_min_x,y,z, rm_max_x,y,z
  output      logic                        out_tuser,  // box_valid
  output      logic                        out_tlast
);

  localparam int N  = lmws_pkg::NUM_AXES;
  localparam int CW = lmws_pkg::COORD_W;

  logic             buf_vld_r;
  lmws_pkg::batch_t buf_r;
  logic [N-1:0]     rem_r;
  logic [N-1:0]     rem_nxt;
  logic [N-1:0]     sel_oh;
  logic             last;
  logic             xfer;
  logic             done;

  // Lowest axis still owed a box goes out first.
  assign sel_oh = rem_r & (~rem_r + N'(1));
  assign last   = !buf_r.has_box || (rem_r == sel_oh);
  assign xfer   = buf_vld_r && out_tready;
  assign done   = xfer && last;
  assign free   = !buf_vld_r || done;

  assign out_tvalid = buf_vld_r;
  assign out_tuser  = buf_r.has_box;
  assign out_tlast  = last;

  // Old cube with the selected axis cut to its slab; zeros for an empty result.
  always_comb begin
    for (int a = 0; a < N; a++) begin
      if (!buf_r.has_box) begin
        out_tdata[a*CW +: CW]     = '0;
        out_tdata[(N+a)*CW +: CW] = '0;
      end else begin
        out_tdata[a*CW +: CW]     = (sel_oh[a] && buf_r.at_min[a]) ?
                                    buf_r.cut[a] : buf_r.lo[a];
        out_tdata[(N+a)*CW +: CW] = (sel_oh[a] && !buf_r.at_min[a]) ?
                                    buf_r.cut[a] : buf_r.hi[a];
      end
    end
  end

  assign rem_nxt = rem_r & ~sel_oh;

  // Load a new batch, drop a sent box, release after the last transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      rem_r     <= '0;
    end else if (load) begin
      buf_vld_r <= 1'b1;
      rem_r     <= batch.hit;
    end else if (done) begin
      buf_vld_r <= 1'b0;
    end else if (xfer) begin
      rem_r     <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= batch;
    end
  end

  `LMWS_ASSERT_IMP(a_load_when_free, load, free,
                   "batch loaded over results not yet delivered")
  `LMWS_ASSERT_IMP(a_boxes_pending, buf_vld_r && buf_r.has_box, rem_r != '0,
                   "box batch held with no box left to send")

endmodule

`default_nettype wire

// File: rtl/local_map_window_shift.sv
// A position is registered in the core; its result is offered from the result buffer register.
// Throughput: one position per cycle while each yields one result, out_tready is high
// and no register write is settling; a position that moves n axes yields n results (up to 3).
// A register write holds off positions while margin and move distance run through the
// multiply and divide-by-20 pipeline.
// Reset (rst_n low, synchronous): cube unplaced, registers at defaults, positions held off.
`default_nettype none

module local_map_window_shift (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [lmws_pkg::IN_W-1:0]       in_tdata,   // pos_x, pos_y, pos_z
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [lmws_pkg::OUT_W-1:0]      out_tdata,  // rm_min_x,y,z, rm_max_x,y,z
  output      logic                            out_tuser,  // box_valid
  output      logic                            out_tlast,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [lmws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lmws_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic             settled;
  lmws_pkg::geom_t  geom;
  logic             obuf_free;
  logic             load;
  lmws_pkg::batch_t batch;

  // Registers and derived lengths.
  lmws_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .settled   (settled),
    .geom      (geom)
  );

  // Cube state and face check.
  lmws_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .settled   (settled),
    .geom      (geom),
    .obuf_free (obuf_free),
    .load      (load),
    .batch     (batch)
  );

  // Result sequencing.
  lmws_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .batch      (batch),
    .free       (obuf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
